// ----- src/txbrm_pkg.sv -----
// Package: beat payload types, action codes, address map and reset table of the tx buffer block.
package txbrm_pkg;

  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_ADD      = 3'd2,
    ACT_TRANSMIT = 3'd3,
    ACT_EMPTY    = 3'd4
  } action_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_THRESHOLD = 1'd1;

  localparam logic [15:0] CAPACITY_RESET  = 16'd20480;
  localparam logic [15:0] THRESHOLD_RESET = 16'd2560;

  localparam logic [5:0] ADDR_READY    = 6'd19;
  localparam logic [5:0] ADDR_UNDER_HI = 6'd20;
  localparam logic [5:0] ADDR_UNDER_LO = 6'd21;
  localparam logic [5:0] ADDR_OVER_HI  = 6'd22;
  localparam logic [5:0] ADDR_OVER_LO  = 6'd23;
  localparam logic [5:0] ADDR_FILL_HI  = 6'd24;
  localparam logic [5:0] ADDR_FILL_LO  = 6'd25;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  reg_address;
    logic [7:0]  write_data;
    logic [11:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bad_address;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  function automatic logic addr_ok(input logic [5:0] a);
    logic ok;
    ok = (a <= 6'd1) || ((a >= 6'd3) && (a <= 6'd5)) || ((a >= 6'd17) && (a <= 6'd41));
    return ok;
  endfunction

  function automatic logic addr_live(input logic [5:0] a);
    logic live;
    live = (a >= ADDR_READY) && (a <= ADDR_FILL_LO);
    return live;
  endfunction

  function automatic logic [7:0] reset_byte(input logic [5:0] a);
    logic [7:0] b;
    unique case (a) inside
      6'd5:            b = 8'd1;
      6'd17:           b = 8'd30;
      6'd18:           b = 8'd3;
      [6'd26:6'd29]:   b = 8'd8;
      6'd30:           b = 8'd50;
      6'd32:           b = 8'd255;
      6'd33, 6'd38:    b = 8'd192;
      6'd34, 6'd35:    b = 8'd8;
      6'd36, 6'd37:    b = 8'd16;
      6'd39:           b = 8'd64;
      6'd41:           b = 8'd9;
      default:         b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- src/txbrm_if.sv -----
// Interfaces: valid/ready channels carrying the request and response beats.
interface txbrm_in_if;
  logic                 valid;
  logic                 ready;
  txbrm_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface txbrm_out_if;
  logic                 valid;
  logic                 ready;
  txbrm_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/tx_buffer_register_model.sv -----
// Top level: transmitter register file with a transmit buffer occupancy model.
// Each request beat (read, write, add bytes, transmit bytes, empty buffer) yields one
// response beat. A request is latched, which starts the register RAM read through its
// registered read port, then executed, which applies the update and loads the response
// register; a new request is taken only once a waiting response is taken, at the
// earliest in the same cycle, and never while one executes. Plain registers come up at
// their defaults after reset with no clearing pass; addresses 19 to 25 are the ready
// flag and the underrun, overrun and fill counters. Capacity and threshold are set via
// the configuration write port; the user must do so only while idle (not enforced).
module tx_buffer_register_model #(
  parameter int unsigned REG_COUNT = 42
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  txbrm_in_if.sink                          in_i,
  txbrm_out_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [txbrm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [txbrm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  txbrm_pkg::ctrl_cmd_t cmd;

  txbrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  txbrm_datapath #(
    .REG_COUNT (REG_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_i.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_o.payload)
  );

endmodule

// ----- src/txbrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module txbrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/txbrm_ctrl.sv -----
// Controller: two-state sequencer for capture and execute, owns the response valid flag.
module txbrm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output txbrm_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        out_valid_q;
  logic        in_accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = in_accept;
  assign cmd_o.execute = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!out_valid_q || out_ready_i))
    else $error("response register busy at request accept");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("execute did not produce a response");

  a_resp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept, 2))
    else $error("response without a request");

  a_exec_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !in_ready_o)
    else $error("request taken during execute");
`endif

endmodule

// ----- src/txbrm_datapath.sv -----
// Datapath: request latch, register RAM, buffer occupancy counters and response register.
module txbrm_datapath #(
  parameter int unsigned REG_COUNT = 42
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  txbrm_pkg::ctrl_cmd_t                cmd_i,
  input  txbrm_pkg::in_item_t                 in_item_i,
  input  logic                                cfg_we_i,
  input  logic [txbrm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [txbrm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output txbrm_pkg::out_item_t                out_item_o
);

  localparam int unsigned IDX_W = $clog2(REG_COUNT);

  txbrm_pkg::in_item_t  item_q;
  txbrm_pkg::out_item_t out_q, out_d;
  logic [15:0]          cap_q, thr_q;
  logic [15:0]          fill_q, fill_d;
  logic [15:0]          under_q, under_d;
  logic [15:0]          over_q, over_d;
  logic                 ready_q, ready_d;
  logic [REG_COUNT-1:0] valid_q;

  logic [5:0]           addr;
  logic [IDX_W-1:0]     idx;
  logic                 ok;
  logic                 live;
  logic [7:0]           ram_rdata;
  logic [7:0]           plain_rd;
  logic [7:0]           live_rd;
  logic                 ram_we;
  logic [15:0]          n16, room, added, excess, taken, shortfall, fill_add, fill_tx;

  assign addr = item_q.reg_address;
  assign idx  = IDX_W'(addr);
  assign ok   = txbrm_pkg::addr_ok(addr) && (7'(addr) < 7'(REG_COUNT));
  assign live = txbrm_pkg::addr_live(addr);

  assign ram_we = cmd_i.execute && (item_q.action == txbrm_pkg::ACT_WRITE) && ok && !live;

  txbrm_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (item_q.write_data),
    .raddr_i (IDX_W'(in_item_i.reg_address)),
    .rdata_o (ram_rdata)
  );

  assign plain_rd = valid_q[idx] ? ram_rdata : txbrm_pkg::reset_byte(addr);

  always_comb begin
    unique case (addr)
      txbrm_pkg::ADDR_READY:    live_rd = {7'd0, ready_q};
      txbrm_pkg::ADDR_UNDER_HI: live_rd = under_q[15:8];
      txbrm_pkg::ADDR_UNDER_LO: live_rd = under_q[7:0];
      txbrm_pkg::ADDR_OVER_HI:  live_rd = over_q[15:8];
      txbrm_pkg::ADDR_OVER_LO:  live_rd = over_q[7:0];
      txbrm_pkg::ADDR_FILL_HI:  live_rd = fill_q[15:8];
      txbrm_pkg::ADDR_FILL_LO:  live_rd = fill_q[7:0];
      default:                  live_rd = plain_rd;
    endcase
  end

  assign n16       = {4'd0, item_q.byte_count};
  assign room      = (cap_q > fill_q) ? (cap_q - fill_q) : 16'd0;
  assign added     = (n16 < room) ? n16 : room;
  assign excess    = n16 - added;
  assign fill_add  = fill_q + added;
  assign taken     = (n16 < fill_q) ? n16 : fill_q;
  assign shortfall = n16 - taken;
  assign fill_tx   = fill_q - taken;

  always_comb begin
    fill_d  = fill_q;
    under_d = under_q;
    over_d  = over_q;
    ready_d = ready_q;
    out_d   = '0;
    case (item_q.action)
      txbrm_pkg::ACT_READ: begin
        if (ok) begin
          out_d.read_data = live_rd;
        end else begin
          out_d.bad_address = 1'b1;
        end
      end
      txbrm_pkg::ACT_WRITE: begin
        if (ok) begin
          unique case (addr)
            txbrm_pkg::ADDR_READY:    ready_d = item_q.write_data[0];
            txbrm_pkg::ADDR_UNDER_HI: under_d = {item_q.write_data, under_q[7:0]};
            txbrm_pkg::ADDR_UNDER_LO: under_d = {under_q[15:8], item_q.write_data};
            txbrm_pkg::ADDR_OVER_HI:  over_d  = {item_q.write_data, over_q[7:0]};
            txbrm_pkg::ADDR_OVER_LO:  over_d  = {over_q[15:8], item_q.write_data};
            txbrm_pkg::ADDR_FILL_HI:  fill_d  = {item_q.write_data, fill_q[7:0]};
            txbrm_pkg::ADDR_FILL_LO:  fill_d  = {fill_q[15:8], item_q.write_data};
            default:                  fill_d  = fill_q;
          endcase
        end else begin
          out_d.bad_address = 1'b1;
        end
      end
      txbrm_pkg::ACT_ADD: begin
        fill_d = fill_add;
        over_d = over_q + excess;
        if ((excess != 16'd0) || ((added != 16'd0) && (fill_add > thr_q))) begin
          ready_d = 1'b0;
        end
      end
      txbrm_pkg::ACT_TRANSMIT: begin
        fill_d  = fill_tx;
        under_d = under_q + shortfall;
        if ((shortfall != 16'd0) || ((taken != 16'd0) && (fill_tx <= thr_q))) begin
          ready_d = 1'b1;
        end
      end
      txbrm_pkg::ACT_EMPTY: begin
        fill_d = 16'd0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= txbrm_pkg::CAPACITY_RESET;
      thr_q   <= txbrm_pkg::THRESHOLD_RESET;
      fill_q  <= 16'd0;
      under_q <= 16'd0;
      over_q  <= 16'd0;
      ready_q <= 1'b1;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          txbrm_pkg::CFG_BUFFER_CAPACITY: cap_q <= cfg_data_i;
          txbrm_pkg::CFG_READY_THRESHOLD: thr_q <= cfg_data_i;
          default:                        cap_q <= cap_q;
        endcase
      end
      if (cmd_i.execute) begin
        fill_q  <= fill_d;
        under_q <= under_d;
        over_q  <= over_d;
        ready_q <= ready_d;
      end
      if (ram_we) begin
        valid_q[idx] <= 1'b1;
      end
    end
  end

  assign out_item_o = out_q;

endmodule
